// ===== hdl/rob_pkg.sv =====
package rob_pkg;

  localparam int IN_W   = 280;
  localparam int OUT_W  = 112;
  localparam int ANGW   = 19;
  localparam int EPSW   = 17;
  localparam int TW     = 39;
  localparam int ATAN_N = 24;
  localparam int CW     = 34;
  localparam int ZW     = 35;
  localparam int MW     = 66;
  localparam int HW     = 34;
  localparam int VW     = 36;
  localparam int EW     = 37;
  localparam int AW     = 37;
  localparam int DENW   = 70;
  localparam int NUMW   = 75;
  localparam int DVW    = 64;
  localparam int NMW    = 68;
  localparam int SNW    = NMW + 16;
  localparam int QLW    = 20;
  localparam int QHW    = TW - QLW;
  localparam int PLW    = 32 + QLW + 1;
  localparam int PHW    = 32 + QHW + 1;
  localparam int PFW    = 72;
  localparam int PW     = 58;
  localparam int UW     = 59;
  localparam int ULW    = 29;
  localparam int PPW    = EW + UW - ULW;
  localparam int DOTW   = 98;

  localparam logic [0:0] REG_EPSILON   = 1'b0;
  localparam logic [0:0] REG_FAR_LIMIT = 1'b1;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } ray_t;

  typedef struct packed {
    ray_t               ray;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        w;
    logic [30:0]        h;
  } box_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
  } vtx_t;

  typedef struct packed {
    ray_t ray;
    vtx_t p0;
    vtx_t p1;
  } ectx_t;

  typedef struct packed {
    logic                 vld;
    logic                 hit;
    logic [TW-1:0]        t;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
  } ehit_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h3243F6A8;
      5'd1:  a = 32'h1DAC6705;
      5'd2:  a = 32'h0FADBAFC;
      5'd3:  a = 32'h07F56EA6;
      5'd4:  a = 32'h03FEAB76;
      5'd5:  a = 32'h01FFD55B;
      5'd6:  a = 32'h00FFFAAA;
      5'd7:  a = 32'h007FFF55;
      5'd8:  a = 32'h003FFFEA;
      5'd9:  a = 32'h001FFFFD;
      5'd10: a = 32'h000FFFFF;
      5'd11: a = 32'h0007FFFF;
      5'd12: a = 32'h0003FFFF;
      5'd13: a = 32'h0001FFFF;
      5'd14: a = 32'h0000FFFF;
      5'd15: a = 32'h00007FFF;
      5'd16: a = 32'h00003FFF;
      5'd17: a = 32'h00001FFF;
      5'd18: a = 32'h00000FFF;
      5'd19: a = 32'h000007FF;
      5'd20: a = 32'h000003FF;
      5'd21: a = 32'h000001FF;
      5'd22: a = 32'h000000FF;
      5'd23: a = 32'h0000007F;
      default: a = 32'h0;
    endcase
    return signed'(ZW'(a));
  endfunction

  function automatic logic [31:0] sat32(input logic signed [PW-1:0] v);
    logic [31:0] r;
    if ((&v[PW-1:31]) || (~|v[PW-1:31])) begin
      r = v[31:0];
    end else if (v[PW-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== hdl/rob_edge.sv =====
module rob_edge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  rob_pkg::ray_t              ray_i,
  input  rob_pkg::vtx_t              p0_i,
  input  rob_pkg::vtx_t              p1_i,
  input  logic [rob_pkg::EPSW-1:0]   eps_i,
  input  logic [rob_pkg::TW-1:0]     far_i,
  output rob_pkg::ehit_t             res_o
);
  import rob_pkg::*;

  // normal and offset to the first corner
  logic                  s1_v_q;
  ectx_t                 s1_c_q;
  logic signed [EW-1:0]  s1_nx_q, s1_ny_q;
  logic signed [AW-1:0]  s1_ax_q, s1_ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_c_q.ray <= ray_i;
      s1_c_q.p0  <= p0_i;
      s1_c_q.p1  <= p1_i;
      s1_nx_q    <= EW'(p1_i.y) - EW'(p0_i.y);
      s1_ny_q    <= EW'(p0_i.x) - EW'(p1_i.x);
      s1_ax_q    <= AW'(p0_i.x) - AW'(ray_i.ox);
      s1_ay_q    <= AW'(p0_i.y) - AW'(ray_i.oy);
    end
  end

  // dot product terms
  logic                   s2_v_q;
  ectx_t                  s2_c_q;
  logic signed [DENW-1:0] s2_pdx_q, s2_pdy_q;
  logic signed [NUMW-1:0] s2_pax_q, s2_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en_i) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_c_q   <= s1_c_q;
      s2_pdx_q <= DENW'(s1_c_q.ray.dx) * DENW'(s1_nx_q);
      s2_pdy_q <= DENW'(s1_c_q.ray.dy) * DENW'(s1_ny_q);
      s2_pax_q <= NUMW'(s1_ax_q) * NUMW'(s1_nx_q);
      s2_pay_q <= NUMW'(s1_ay_q) * NUMW'(s1_ny_q);
    end
  end

  logic                   s3_v_q;
  ectx_t                  s3_c_q;
  logic signed [DENW-1:0] s3_den_q;
  logic signed [NUMW-1:0] s3_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en_i) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_c_q   <= s2_c_q;
      s3_den_q <= s2_pdx_q + s2_pdy_q;
      s3_num_q <= s2_pax_q + s2_pay_q;
    end
  end

  // magnitudes, sign test and quotient range test
  logic signed [DENW-1:0] den_abs;
  logic signed [NUMW-1:0] num_abs;
  logic [DVW-1:0]         dv4;
  logic [SNW-1:0]         sn4;
  logic                   ok4;

  always_comb begin
    den_abs = s3_den_q[DENW-1] ? -s3_den_q : s3_den_q;
    num_abs = s3_num_q[NUMW-1] ? -s3_num_q : s3_num_q;
    dv4     = den_abs[DVW-1:0];
    sn4     = {num_abs[NMW-1:0], 16'b0};
    ok4     = (s3_den_q != '0) && (s3_num_q != '0) &&
              (s3_den_q[DENW-1] == s3_num_q[NUMW-1]) &&
              (DVW'(sn4[SNW-1:TW]) < dv4);
  end

  // restoring divider, one quotient bit per stage, 64-bit partial remainder
  logic           dv_q  [TW+1];
  logic           dok_q [TW+1];
  logic [DVW-1:0] ddv_q [TW+1];
  logic [DVW-1:0] dr_q  [TW+1];
  logic [TW-1:0]  dl_q  [TW+1];
  ectx_t          dc_q  [TW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dok_q[0] <= ok4;
      ddv_q[0] <= dv4;
      dr_q[0]  <= DVW'(sn4[SNW-1:TW]);
      dl_q[0]  <= sn4[TW-1:0];
      dc_q[0]  <= s3_c_q;
    end
  end

  for (genvar k = 0; k < TW; k++) begin : g_div
    logic [DVW:0] r2, df;
    logic         ge;

    assign r2 = {1'b0, dr_q[k][DVW-2:0], dl_q[k][TW-1]};
    assign df = r2 - {1'b0, ddv_q[k]};
    assign ge = !df[DVW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dok_q[k+1] <= dok_q[k];
        ddv_q[k+1] <= ddv_q[k];
        dr_q[k+1]  <= ge ? df[DVW-1:0] : r2[DVW-1:0];
        dl_q[k+1]  <= {dl_q[k][TW-2:0], ge};
        dc_q[k+1]  <= dc_q[k];
      end
    end
  end

  // limits and direction times time
  logic [TW-1:0] qd;
  logic          okq;

  assign qd  = dl_q[TW];
  assign okq = dok_q[TW] && (qd < far_i) && (qd > TW'(eps_i));

  logic                  sq_v_q, sq_ok_q;
  logic [TW-1:0]         sq_t_q;
  ectx_t                 sq_c_q;
  logic signed [PLW-1:0] sq_plx_q, sq_ply_q;
  logic signed [PHW-1:0] sq_phx_q, sq_phy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else if (en_i) begin
      sq_v_q <= dv_q[TW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_ok_q  <= okq;
      sq_t_q   <= qd;
      sq_c_q   <= dc_q[TW];
      sq_plx_q <= PLW'(dc_q[TW].ray.dx) * PLW'(signed'({1'b0, qd[QLW-1:0]}));
      sq_ply_q <= PLW'(dc_q[TW].ray.dy) * PLW'(signed'({1'b0, qd[QLW-1:0]}));
      sq_phx_q <= PHW'(dc_q[TW].ray.dx) * PHW'(signed'({1'b0, qd[TW-1:QLW]}));
      sq_phy_q <= PHW'(dc_q[TW].ray.dy) * PHW'(signed'({1'b0, qd[TW-1:QLW]}));
    end
  end

  // hit point
  logic signed [PFW-1:0] fx, fy;

  assign fx = (PFW'(sq_phx_q) <<< QLW) + PFW'(sq_plx_q);
  assign fy = (PFW'(sq_phy_q) <<< QLW) + PFW'(sq_ply_q);

  logic                 sx_v_q, sx_ok_q;
  logic [TW-1:0]        sx_t_q;
  ectx_t                sx_c_q;
  logic signed [PW-1:0] sx_px_q, sx_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_v_q <= 1'b0;
    end else if (en_i) begin
      sx_v_q <= sq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_ok_q <= sq_ok_q;
      sx_t_q  <= sq_t_q;
      sx_c_q  <= sq_c_q;
      sx_px_q <= PW'(sq_c_q.ray.ox) + PW'(fx >>> 16);
      sx_py_q <= PW'(sq_c_q.ray.oy) + PW'(fy >>> 16);
    end
  end

  // offsets of the point from both corners
  logic                 su_v_q, su_ok_q;
  logic [TW-1:0]        su_t_q;
  logic signed [PW-1:0] su_px_q, su_py_q;
  logic signed [EW-1:0] su_ex_q, su_ey_q;
  logic signed [UW-1:0] su_ux_q, su_uy_q, su_wx_q, su_wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      su_v_q <= 1'b0;
    end else if (en_i) begin
      su_v_q <= sx_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      su_ok_q <= sx_ok_q;
      su_t_q  <= sx_t_q;
      su_px_q <= sx_px_q;
      su_py_q <= sx_py_q;
      su_ex_q <= EW'(sx_c_q.p1.x) - EW'(sx_c_q.p0.x);
      su_ey_q <= EW'(sx_c_q.p1.y) - EW'(sx_c_q.p0.y);
      su_ux_q <= UW'(sx_px_q) - UW'(sx_c_q.p0.x);
      su_uy_q <= UW'(sx_py_q) - UW'(sx_c_q.p0.y);
      su_wx_q <= UW'(sx_c_q.p1.x) - UW'(sx_px_q);
      su_wy_q <= UW'(sx_c_q.p1.y) - UW'(sx_py_q);
    end
  end

  // on-edge products as partial products
  logic signed [EW-1:0] me [4];
  logic signed [UW-1:0] mu [4];

  assign me[0] = su_ex_q;
  assign me[1] = su_ey_q;
  assign me[2] = su_ex_q;
  assign me[3] = su_ey_q;
  assign mu[0] = su_ux_q;
  assign mu[1] = su_uy_q;
  assign mu[2] = su_wx_q;
  assign mu[3] = su_wy_q;

  logic                  sm_v_q, sm_ok_q;
  logic [TW-1:0]         sm_t_q;
  logic signed [PW-1:0]  sm_px_q, sm_py_q;
  logic signed [PPW-1:0] sm_lo_q [4];
  logic signed [PPW-1:0] sm_hi_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_v_q <= 1'b0;
    end else if (en_i) begin
      sm_v_q <= su_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sm_ok_q <= su_ok_q;
      sm_t_q  <= su_t_q;
      sm_px_q <= su_px_q;
      sm_py_q <= su_py_q;
      for (int k = 0; k < 4; k++) begin
        sm_lo_q[k] <= PPW'(me[k]) * PPW'(signed'({1'b0, mu[k][ULW-1:0]}));
        sm_hi_q[k] <= PPW'(me[k]) * PPW'($signed(mu[k][UW-1:ULW]));
      end
    end
  end

  logic                   sc_v_q, sc_ok_q;
  logic [TW-1:0]          sc_t_q;
  logic signed [PW-1:0]   sc_px_q, sc_py_q;
  logic signed [DOTW-1:0] sc_p_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else if (en_i) begin
      sc_v_q <= sm_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_ok_q <= sm_ok_q;
      sc_t_q  <= sm_t_q;
      sc_px_q <= sm_px_q;
      sc_py_q <= sm_py_q;
      for (int k = 0; k < 4; k++) begin
        sc_p_q[k] <= (DOTW'(sm_hi_q[k]) <<< ULW) + DOTW'(sm_lo_q[k]);
      end
    end
  end

  logic signed [DOTW-1:0] dot0, dot1;

  assign dot0 = sc_p_q[0] + sc_p_q[1];
  assign dot1 = sc_p_q[2] + sc_p_q[3];

  logic                 res_v_q, res_hit_q;
  logic [TW-1:0]        res_t_q;
  logic signed [PW-1:0] res_px_q, res_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (en_i) begin
      res_v_q <= sc_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_hit_q <= sc_ok_q && !dot0[DOTW-1] && !dot1[DOTW-1];
      res_t_q   <= sc_t_q;
      res_px_q  <= sc_px_q;
      res_py_q  <= sc_py_q;
    end
  end

  assign res_o = {res_v_q, res_hit_q, res_t_q, res_px_q, res_py_q};

endmodule

// ===== hdl/ray_obb_intersect.sv =====
// throughput: one item per cycle while the output is not stalled, set by the fully
// pipelined cordic and the 39-stage divider
// a stalled output freezes the whole pipeline; input ready follows the output register
// reset (async, active low) clears all valid bits; epsilon returns to 7, far_limit to 6553600000
module ray_obb_intersect #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // origin_x, origin_y, dir_x, dir_y, center_x, center_y, width, height, angle
  input  logic [rob_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // hit_time, point_x, point_y, edge_index
  output logic [rob_pkg::OUT_W-1:0]   m_axis_tdata,
  // hit
  output logic [0:0]                  m_axis_tuser,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [0:0]                  cfg_index_i,
  input  logic [rob_pkg::TW-1:0]      cfg_data_i
);
  import rob_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

  logic            adv;
  logic [EPSW-1:0] eps_q;
  logic [TW-1:0]   far_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPSW'(7);
      far_q <= 39'd6553600000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_EPSILON:   eps_q <= cfg_data_i[EPSW-1:0];
        REG_FAR_LIMIT: far_q <= cfg_data_i;
      endcase
    end
  end

  // input register
  box_t in_box;

  assign in_box.ray.ox = s_axis_tdata[31:0];
  assign in_box.ray.oy = s_axis_tdata[63:32];
  assign in_box.ray.dx = s_axis_tdata[95:64];
  assign in_box.ray.dy = s_axis_tdata[127:96];
  assign in_box.cx     = s_axis_tdata[159:128];
  assign in_box.cy     = s_axis_tdata[191:160];
  assign in_box.w      = s_axis_tdata[222:192];
  assign in_box.h      = s_axis_tdata[253:223];

  logic                   s0_v_q;
  box_t                   s0_box_q;
  logic signed [ANGW-1:0] s0_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_box_q <= in_box;
      s0_ang_q <= s_axis_tdata[272:254];
    end
  end

  // angle range reduction
  logic signed [ZW-1:0] z_raw, z_red;
  logic                 flip;

  always_comb begin
    z_raw = ZW'(s0_ang_q) <<< 14;
    z_red = z_raw;
    flip  = 1'b0;
    if (z_raw > HALF_PI_Q30) begin
      z_red = z_raw - PI_Q30;
      flip  = 1'b1;
    end else if (z_raw < -HALF_PI_Q30) begin
      z_red = z_raw + PI_Q30;
      flip  = 1'b1;
    end
  end

  // cordic, one rotation per stage
  logic                 cv_q [NSTEP+1];
  logic signed [CW-1:0] cx_q [NSTEP+1];
  logic signed [CW-1:0] cy_q [NSTEP+1];
  logic signed [ZW-1:0] cz_q [NSTEP+1];
  logic                 cf_q [NSTEP+1];
  box_t                 cb_q [NSTEP+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (adv) begin
      cv_q[0] <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0] <= GAIN_Q30;
      cy_q[0] <= '0;
      cz_q[0] <= z_red;
      cf_q[0] <= flip;
      cb_q[0] <= s0_box_q;
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_cordic
    logic signed [CW-1:0] xs, ys;
    logic                 fwd;

    assign xs  = cx_q[k] >>> k;
    assign ys  = cy_q[k] >>> k;
    assign fwd = !cz_q[k][ZW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else if (adv) begin
        cv_q[k+1] <= cv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[k+1] <= fwd ? cx_q[k] - ys : cx_q[k] + ys;
        cy_q[k+1] <= fwd ? cy_q[k] + xs : cy_q[k] - xs;
        cz_q[k+1] <= fwd ? cz_q[k] - atan_q30(5'(k)) : cz_q[k] + atan_q30(5'(k));
        cf_q[k+1] <= cf_q[k];
        cb_q[k+1] <= cb_q[k];
      end
    end
  end

  // half extents
  logic signed [CW-1:0] cos_v, sin_v;
  logic signed [MW-1:0] pwc, pws, phc, phs;

  always_comb begin
    cos_v = cf_q[NSTEP] ? -cx_q[NSTEP] : cx_q[NSTEP];
    sin_v = cf_q[NSTEP] ? -cy_q[NSTEP] : cy_q[NSTEP];
    pwc   = MW'(signed'({1'b0, cb_q[NSTEP].w})) * MW'(cos_v);
    pws   = MW'(signed'({1'b0, cb_q[NSTEP].w})) * MW'(sin_v);
    phc   = MW'(signed'({1'b0, cb_q[NSTEP].h})) * MW'(cos_v);
    phs   = MW'(signed'({1'b0, cb_q[NSTEP].h})) * MW'(sin_v);
  end

  logic                 hs_v_q;
  box_t                 hs_box_q;
  logic signed [HW-1:0] hs_cw_q, hs_sw_q, hs_ch_q, hs_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_v_q <= 1'b0;
    end else if (adv) begin
      hs_v_q <= cv_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hs_box_q <= cb_q[NSTEP];
      hs_cw_q  <= HW'(pwc >>> 31);
      hs_sw_q  <= HW'(pws >>> 31);
      hs_ch_q  <= HW'(phc >>> 31);
      hs_sh_q  <= HW'(phs >>> 31);
    end
  end

  // corners: top right, top left, bottom left, bottom right
  logic signed [VW-1:0] ccx, ccy, ecw, esw, ech, esh;

  assign ccx = VW'(hs_box_q.cx);
  assign ccy = VW'(hs_box_q.cy);
  assign ecw = VW'(hs_cw_q);
  assign esw = VW'(hs_sw_q);
  assign ech = VW'(hs_ch_q);
  assign esh = VW'(hs_sh_q);

  logic vv_q;
  ray_t vray_q;
  vtx_t vtx_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vv_q <= 1'b0;
    end else if (adv) begin
      vv_q <= hs_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vray_q     <= hs_box_q.ray;
      vtx_q[0].x <= ccx + ecw - esh;
      vtx_q[0].y <= ccy + esw + ech;
      vtx_q[1].x <= ccx - ecw - esh;
      vtx_q[1].y <= ccy - esw + ech;
      vtx_q[2].x <= ccx - ecw + esh;
      vtx_q[2].y <= ccy - esw - ech;
      vtx_q[3].x <= ccx + ecw + esh;
      vtx_q[3].y <= ccy + esw - ech;
    end
  end

  // edges: top, left, bottom, right
  ehit_t eres [4];

  for (genvar k = 0; k < 4; k++) begin : g_side
    rob_edge u_side (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vv_q),
      .ray_i   (vray_q),
      .p0_i    (vtx_q[k]),
      .p1_i    (vtx_q[(k + 1) % 4]),
      .eps_i   (eps_q),
      .far_i   (far_q),
      .res_o   (eres[k])
    );
  end

  // nearest hit, first edge wins a tie
  logic                 found;
  logic [TW-1:0]        best;
  logic [1:0]           best_k;
  logic signed [PW-1:0] best_px, best_py;
  logic [OUT_W-1:0]     out_d;

  always_comb begin
    found   = 1'b0;
    best    = far_q;
    best_k  = '0;
    best_px = '0;
    best_py = '0;
    for (int k = 0; k < 4; k++) begin
      if (eres[k].hit && (eres[k].t < best)) begin
        found   = 1'b1;
        best    = eres[k].t;
        best_k  = 2'(k);
        best_px = eres[k].px;
        best_py = eres[k].py;
      end
    end
    out_d = '0;
    if (found) begin
      out_d = OUT_W'({best_k, sat32(best_py), sat32(best_px), best});
    end
  end

  logic             om_v_q;
  logic             om_hit_q;
  logic [OUT_W-1:0] om_data_q;

  assign adv = !om_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      om_v_q <= 1'b0;
    end else if (adv) begin
      om_v_q <= eres[0].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      om_hit_q  <= found;
      om_data_q <= out_d;
    end
  end

  assign s_axis_tready   = adv;
  assign m_axis_tvalid   = om_v_q;
  assign m_axis_tdata    = om_data_q;
  assign m_axis_tuser[0] = om_hit_q;

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss result carries nonzero data");

  a_reset_idle : assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a held result");

endmodule
